### rtl/core/scs_pkg.sv
// Shared types and constants for the shortest common supersequence block.
// Depends on nothing; used by every module under rtl/core.
`timescale 1ns / 1ps
package scs_pkg;

  localparam int unsigned MaxLenDef     = 32;
  localparam int unsigned SymbolBitsDef = 8;

  localparam logic [1:0] OpLoadA  = 2'd0;
  localparam logic [1:0] OpLoadB  = 2'd1;
  localparam logic [1:0] OpRun    = 2'd2;
  localparam logic [1:0] OpUnused = 2'd3;

  typedef enum logic [1:0] {
    CMD_LOAD_A,
    CMD_LOAD_B,
    CMD_RUN
  } cmd_kind_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] symbol;
  } in_t;

  typedef struct packed {
    logic [7:0] out_symbol;
    logic       last;
    logic       empty_res;
    logic       truncated;
  } out_t;

  typedef struct packed {
    cmd_kind_e  kind;
    logic [7:0] symbol;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_q_t;

endpackage

### rtl/core/scs_front.sv
// Front end: accepts input transactions, classifies the op and queues commands.
// Depends on scs_pkg.
`timescale 1ns / 1ps
module scs_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  scs_pkg::in_t   in_data_i,
  output scs_pkg::cmd_q_t head_o,
  input  logic           pop_i
);

  scs_pkg::cmd_t ent_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          accept, push;
  scs_pkg::cmd_t cmd;

  assign in_stall_o = (cnt_q == 2'd2);
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    cmd.symbol = in_data_i.symbol;
    cmd.kind   = scs_pkg::CMD_RUN;
    push       = accept;
    unique case (in_data_i.op)
      scs_pkg::OpLoadA: cmd.kind = scs_pkg::CMD_LOAD_A;
      scs_pkg::OpLoadB: cmd.kind = scs_pkg::CMD_LOAD_B;
      scs_pkg::OpRun:   cmd.kind = scs_pkg::CMD_RUN;
      default:          push     = 1'b0;
    endcase
  end

  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.cmd   = ent_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wr_ptr_q] <= cmd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop_i) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop_i};
    end
  end

endmodule

### rtl/core/scs_back.sv
// Back end: string stores, LCS table fill, traceback and result emission.
// Depends on scs_pkg; fed by scs_front.
`timescale 1ns / 1ps
module scs_back #(
  parameter int unsigned MaxLen     = scs_pkg::MaxLenDef,
  parameter int unsigned SymbolBits = scs_pkg::SymbolBitsDef
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  scs_pkg::cmd_q_t head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output scs_pkg::out_t   out_data_o
);

  localparam int unsigned Dim      = MaxLen + 1;
  localparam int unsigned TabDepth = Dim * Dim;
  localparam int unsigned AW       = $clog2(TabDepth);
  localparam int unsigned LW       = $clog2(MaxLen + 1);
  localparam int unsigned SW       = (MaxLen > 1) ? $clog2(MaxLen) : 1;
  localparam int unsigned RDepth   = 2 * MaxLen;
  localparam int unsigned RW       = $clog2(RDepth);
  localparam int unsigned KW       = $clog2(RDepth + 1);
  localparam int unsigned StW      = (SymbolBits < 8) ? SymbolBits : 8;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_FRD   = 3'd1;
  localparam logic [2:0] S_FWR   = 3'd2;
  localparam logic [2:0] S_TRD   = 3'd3;
  localparam logic [2:0] S_TST   = 3'd4;
  localparam logic [2:0] S_ERD   = 3'd5;
  localparam logic [2:0] S_EOUT  = 3'd6;
  localparam logic [2:0] S_EMPTY = 3'd7;

  logic [2:0]     state_q;
  logic [StW-1:0] a_mem [MaxLen];
  logic [StW-1:0] b_mem [MaxLen];
  logic [LW-1:0]  len_a_q, len_b_q, i_q, j_q;
  logic [LW-1:0]  run_m_q, run_n_q;
  logic           dropped_q, trunc_q;
  logic [AW-1:0]  row_q;
  logic [LW-1:0]  left_q, diag_q;
  logic [KW-1:0]  k_q;
  logic [RW-1:0]  p_q;
  logic           out_valid_q;
  scs_pkg::out_t  out_q;

  logic [LW-1:0]  tab_mem [TabDepth];
  logic [LW-1:0]  rd0_q, rd1_q;
  logic [AW-1:0]  raddr0, raddr1, waddr;
  logic           tab_we;
  logic [LW-1:0]  cell_v, up_v, left_v, diag_v;

  logic [StW-1:0] rb_mem [RDepth];
  logic [StW-1:0] rb_rd_q, rb_wdata;
  logic           rb_we;

  logic [StW-1:0] sym_a, sym_b, in_sym;
  logic           we_a, we_b, out_free, out_fire;

  assign in_sym   = head_i.cmd.symbol[StW-1:0];
  assign sym_a    = a_mem[SW'(i_q - LW'(1))];
  assign sym_b    = b_mem[SW'(j_q - LW'(1))];
  assign pop_o    = (state_q == S_IDLE) && head_i.valid;
  assign we_a     = pop_o && (head_i.cmd.kind == scs_pkg::CMD_LOAD_A) &&
                    (len_a_q < LW'(MaxLen));
  assign we_b     = pop_o && (head_i.cmd.kind == scs_pkg::CMD_LOAD_B) &&
                    (len_b_q < LW'(MaxLen));
  assign out_free = !out_valid_q || !out_stall_i;
  assign out_fire = out_free && (state_q == S_EOUT || state_q == S_EMPTY);

  assign raddr0 = row_q - AW'(Dim) + AW'(j_q);
  assign raddr1 = row_q + AW'(j_q) - AW'(1);
  assign waddr  = row_q + AW'(j_q);
  assign tab_we = (state_q == S_FWR);

  always_comb begin
    up_v   = (i_q == LW'(1)) ? '0 : rd0_q;
    left_v = (j_q == LW'(1)) ? '0 : (state_q == S_TST ? rd1_q : left_q);
    diag_v = (i_q == LW'(1) || j_q == LW'(1)) ? '0 : diag_q;
    if (sym_a == sym_b) cell_v = diag_v + LW'(1);
    else                cell_v = (up_v > left_v) ? up_v : left_v;
  end

  always_comb begin
    rb_we    = 1'b0;
    rb_wdata = sym_b;
    if (state_q == S_TST) begin
      rb_we = 1'b1;
      if (sym_a == sym_b || up_v > left_v) rb_wdata = sym_a;
    end else if (state_q == S_TRD && !(i_q != '0 && j_q != '0)) begin
      if (i_q != '0) begin
        rb_we    = 1'b1;
        rb_wdata = sym_a;
      end else if (j_q != '0) begin
        rb_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we_a) a_mem[SW'(len_a_q)] <= in_sym;
    if (we_b) b_mem[SW'(len_b_q)] <= in_sym;
  end

  always_ff @(posedge clk_i) begin
    if (tab_we) tab_mem[waddr] <= cell_v;
    rd0_q <= tab_mem[raddr0];
    rd1_q <= tab_mem[raddr1];
  end

  always_ff @(posedge clk_i) begin
    if (rb_we) rb_mem[k_q[RW-1:0]] <= rb_wdata;
    rb_rd_q <= rb_mem[p_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      len_a_q     <= '0;
      len_b_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      dropped_q   <= 1'b0;
      trunc_q     <= 1'b0;
      row_q       <= '0;
      left_q      <= '0;
      diag_q      <= '0;
      k_q         <= '0;
      p_q         <= '0;
      out_q       <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            unique case (head_i.cmd.kind)
              scs_pkg::CMD_LOAD_A: begin
                if (we_a) len_a_q <= len_a_q + LW'(1);
                else      dropped_q <= 1'b1;
              end
              scs_pkg::CMD_LOAD_B: begin
                if (we_b) len_b_q <= len_b_q + LW'(1);
                else      dropped_q <= 1'b1;
              end
              default: begin
                trunc_q   <= dropped_q;
                dropped_q <= 1'b0;
                len_a_q   <= '0;
                len_b_q   <= '0;
                k_q       <= '0;
                if (len_a_q == '0 && len_b_q == '0) begin
                  state_q <= S_EMPTY;
                end else if (len_a_q == '0 || len_b_q == '0) begin
                  i_q     <= len_a_q;
                  j_q     <= len_b_q;
                  state_q <= S_TRD;
                end else begin
                  i_q     <= LW'(1);
                  j_q     <= LW'(1);
                  row_q   <= AW'(Dim);
                  state_q <= S_FRD;
                end
              end
            endcase
          end
        end
        S_FRD: state_q <= S_FWR;
        S_FWR: begin
          left_q <= cell_v;
          diag_q <= up_v;
          if (j_q == run_n_q) begin
            if (i_q == run_m_q) begin
              state_q <= S_TRD;
              j_q     <= run_n_q;
            end else begin
              i_q     <= i_q + LW'(1);
              j_q     <= LW'(1);
              row_q   <= row_q + AW'(Dim);
              state_q <= S_FRD;
            end
          end else begin
            j_q     <= j_q + LW'(1);
            state_q <= S_FRD;
          end
        end
        S_TRD: begin
          if (i_q != '0 && j_q != '0) begin
            state_q <= S_TST;
          end else if (i_q != '0) begin
            i_q <= i_q - LW'(1);
            k_q <= k_q + KW'(1);
          end else if (j_q != '0) begin
            j_q <= j_q - LW'(1);
            k_q <= k_q + KW'(1);
          end else begin
            p_q     <= RW'(k_q - KW'(1));
            state_q <= S_ERD;
          end
        end
        S_TST: begin
          k_q     <= k_q + KW'(1);
          state_q <= S_TRD;
          if (sym_a == sym_b) begin
            i_q   <= i_q - LW'(1);
            j_q   <= j_q - LW'(1);
            row_q <= row_q - AW'(Dim);
          end else if (up_v > left_v) begin
            i_q   <= i_q - LW'(1);
            row_q <= row_q - AW'(Dim);
          end else begin
            j_q <= j_q - LW'(1);
          end
        end
        S_ERD: state_q <= S_EOUT;
        S_EOUT: begin
          if (out_free) begin
            out_q.out_symbol     <= 8'(rb_rd_q);
            out_q.last           <= (p_q == '0);
            out_q.empty_res      <= 1'b0;
            out_q.truncated      <= trunc_q;
            if (p_q == '0) begin
              state_q <= S_IDLE;
            end else begin
              p_q     <= p_q - RW'(1);
              state_q <= S_ERD;
            end
          end
        end
        default: begin
          if (out_free) begin
            out_q.out_symbol <= '0;
            out_q.last       <= 1'b1;
            out_q.empty_res  <= 1'b1;
            out_q.truncated  <= trunc_q;
            state_q          <= S_IDLE;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_m_q <= '0;
      run_n_q <= '0;
    end else if (pop_o && head_i.cmd.kind == scs_pkg::CMD_RUN) begin
      run_m_q <= len_a_q;
      run_n_q <= len_b_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/core/shortest_common_supersequence.sv
// Shortest common supersequence of two loaded symbol strings.
// Input transactions carry {op, symbol}: op 0 appends to the first string,
// op 1 to the second, op 2 runs the computation, op 3 is dropped.
// Output transactions carry {out_symbol, last, empty_res, truncated}, one per
// supersequence symbol in forward order, last set on the final one.
// Two empty strings give a single transaction with empty_res set.
// The back end takes each load while idle; a run of lengths m and n fills
// m*n cells in a read and a write state each (one table read and one write
// per cell on the single-write table memory), traces back in a read and a
// test state per step while both strings have symbols left, else in a read
// state only, closes, and emits each symbol in a read and an output state.
// A two-entry command queue sits between the front end and the back end, so
// loads keep arriving while a run is in progress until the queue fills.
// Reset clears both string lengths, the drop flag, the queue and the output
// register. When the receiver stalls, the output holds and the back end waits.
// Depends on scs_pkg, scs_front and scs_back.
`timescale 1ns / 1ps
module shortest_common_supersequence #(
  parameter int unsigned MaxLen     = scs_pkg::MaxLenDef,
  parameter int unsigned SymbolBits = scs_pkg::SymbolBitsDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  scs_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output scs_pkg::out_t out_data_o
);

  scs_pkg::cmd_q_t head;
  logic            pop;

  scs_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .head_o     (head),
    .pop_i      (pop)
  );

  scs_back #(
    .MaxLen     (MaxLen),
    .SymbolBits (SymbolBits)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
